// File: hw/rtl/cas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock set and alarm controller package
// Shared types, operation and step codes, field limits and the alarm reset time.
// ----------------------------------------------------------------------------
package cas_pkg;

  // Operation codes carried by an input transaction.
  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_ALARM_SET = 3'd1;
  localparam logic [2:0] OP_INC       = 3'd2;
  localparam logic [2:0] OP_DEC       = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  // Date/time edit step codes.
  localparam logic [2:0] TS_NORMAL = 3'd0;
  localparam logic [2:0] TS_YEAR   = 3'd1;
  localparam logic [2:0] TS_MONTH  = 3'd2;
  localparam logic [2:0] TS_DAY    = 3'd3;
  localparam logic [2:0] TS_HOUR   = 3'd4;
  localparam logic [2:0] TS_MINUTE = 3'd5;
  localparam logic [2:0] TS_SECOND = 3'd6;

  // Alarm edit step codes.
  localparam logic [1:0] AS_NORMAL = 2'd0;
  localparam logic [1:0] AS_HOUR   = 2'd1;
  localparam logic [1:0] AS_MINUTE = 2'd2;

  // Width of the shared wrap unit; the widest field is the year.
  localparam int unsigned FieldW = 7;

  // Field limits, year kept as an offset from 2000.
  localparam logic [FieldW-1:0] YEAR_MIN   = 7'd0;
  localparam logic [FieldW-1:0] YEAR_MAX   = 7'd99;
  localparam logic [FieldW-1:0] MONTH_MIN  = 7'd1;
  localparam logic [FieldW-1:0] MONTH_MAX  = 7'd12;
  localparam logic [FieldW-1:0] DAY_MIN    = 7'd1;
  localparam logic [FieldW-1:0] DAY_MAX    = 7'd31;
  localparam logic [FieldW-1:0] HOUR_MIN   = 7'd0;
  localparam logic [FieldW-1:0] HOUR_MAX   = 7'd23;
  localparam logic [FieldW-1:0] MINSEC_MIN = 7'd0;
  localparam logic [FieldW-1:0] MINSEC_MAX = 7'd59;

  // Alarm time after reset.
  localparam logic [4:0] WAKE_HOUR_RST   = 5'd6;
  localparam logic [5:0] WAKE_MINUTE_RST = 6'd30;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] now_year;
    logic [3:0] now_month;
    logic [4:0] now_day;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic       alarm_switch;
  } in_item_t;

  typedef struct packed {
    logic [2:0] time_step;
    logic [1:0] alarm_step;
    logic [6:0] edit_year;
    logic [3:0] edit_month;
    logic [4:0] edit_day;
    logic [4:0] edit_hour;
    logic [5:0] edit_minute;
    logic [5:0] edit_second;
    logic [4:0] wake_hour;
    logic [5:0] wake_minute;
    logic       commit_time;
    logic       ring;
  } out_item_t;

endpackage

// File: hw/rtl/cas_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Field wrap unit
// Steps one field up or down by one and wraps it inside [lo, hi].
// ----------------------------------------------------------------------------
module cas_wrap (
  input  logic [cas_pkg::FieldW-1:0] value_i,
  input  logic [cas_pkg::FieldW-1:0] lo_i,
  input  logic [cas_pkg::FieldW-1:0] hi_i,
  input  logic                       up_i,
  output logic [cas_pkg::FieldW-1:0] value_o
);

  logic [cas_pkg::FieldW:0] inc;

  // One extra bit so that the largest raw value does not roll over to zero.
  assign inc = {1'b0, value_i} + {{cas_pkg::FieldW{1'b0}}, 1'b1};

  always_comb begin
    if (up_i) begin
      value_o = (inc > {1'b0, hi_i}) ? lo_i : inc[cas_pkg::FieldW-1:0];
    end else begin
      value_o = (value_i <= lo_i) ? hi_i : value_i - {{(cas_pkg::FieldW-1){1'b0}}, 1'b1};
    end
  end

endmodule

// File: hw/rtl/cas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edit controller
// Holds the edit steps, the edit buffer and the alarm time, and works out
// the state and result for one transaction.
// ----------------------------------------------------------------------------
module cas_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cas_pkg::in_item_t  item_i,
  output cas_pkg::out_item_t result_o
);

  logic [2:0] time_step_q, time_step_d;
  logic [1:0] alarm_step_q, alarm_step_d;
  logic [6:0] year_q, year_d;
  logic [3:0] month_q, month_d;
  logic [4:0] day_q, day_d;
  logic [4:0] hour_q, hour_d;
  logic [5:0] minute_q, minute_d;
  logic [5:0] second_q, second_d;
  logic [4:0] wake_hour_q, wake_hour_d;
  logic [5:0] wake_minute_q, wake_minute_d;
  logic       commit, ring;

  logic [cas_pkg::FieldW-1:0] adj_val, adj_lo, adj_hi, adj_res;
  logic                       adj_up;

  // Pick the one field that an increment or decrement can touch.
  always_comb begin
    adj_val = '0;
    adj_lo  = '0;
    adj_hi  = '0;
    if (time_step_q != cas_pkg::TS_NORMAL) begin
      case (time_step_q)
        cas_pkg::TS_YEAR: begin
          adj_val = year_q;
          adj_lo  = cas_pkg::YEAR_MIN;
          adj_hi  = cas_pkg::YEAR_MAX;
        end
        cas_pkg::TS_MONTH: begin
          adj_val = {3'b000, month_q};
          adj_lo  = cas_pkg::MONTH_MIN;
          adj_hi  = cas_pkg::MONTH_MAX;
        end
        cas_pkg::TS_DAY: begin
          adj_val = {2'b00, day_q};
          adj_lo  = cas_pkg::DAY_MIN;
          adj_hi  = cas_pkg::DAY_MAX;
        end
        cas_pkg::TS_HOUR: begin
          adj_val = {2'b00, hour_q};
          adj_lo  = cas_pkg::HOUR_MIN;
          adj_hi  = cas_pkg::HOUR_MAX;
        end
        cas_pkg::TS_MINUTE: begin
          adj_val = {1'b0, minute_q};
          adj_lo  = cas_pkg::MINSEC_MIN;
          adj_hi  = cas_pkg::MINSEC_MAX;
        end
        cas_pkg::TS_SECOND: begin
          adj_val = {1'b0, second_q};
          adj_lo  = cas_pkg::MINSEC_MIN;
          adj_hi  = cas_pkg::MINSEC_MAX;
        end
        default: ;
      endcase
    end else if (alarm_step_q == cas_pkg::AS_HOUR) begin
      adj_val = {2'b00, wake_hour_q};
      adj_lo  = cas_pkg::HOUR_MIN;
      adj_hi  = cas_pkg::HOUR_MAX;
    end else begin
      adj_val = {1'b0, wake_minute_q};
      adj_lo  = cas_pkg::MINSEC_MIN;
      adj_hi  = cas_pkg::MINSEC_MAX;
    end
  end

  assign adj_up = (item_i.operation == cas_pkg::OP_INC);

  cas_wrap u_wrap (
    .value_i (adj_val),
    .lo_i    (adj_lo),
    .hi_i    (adj_hi),
    .up_i    (adj_up),
    .value_o (adj_res)
  );

  always_comb begin
    time_step_d   = time_step_q;
    alarm_step_d  = alarm_step_q;
    year_d        = year_q;
    month_d       = month_q;
    day_d         = day_q;
    hour_d        = hour_q;
    minute_d      = minute_q;
    second_d      = second_q;
    wake_hour_d   = wake_hour_q;
    wake_minute_d = wake_minute_q;
    commit        = 1'b0;
    ring          = 1'b0;
    case (item_i.operation)
      cas_pkg::OP_SET: begin
        if (time_step_q == cas_pkg::TS_NORMAL) begin
          year_d      = item_i.now_year;
          month_d     = item_i.now_month;
          day_d       = item_i.now_day;
          hour_d      = item_i.now_hour;
          minute_d    = item_i.now_minute;
          second_d    = item_i.now_second;
          time_step_d = cas_pkg::TS_YEAR;
        end else if (time_step_q >= cas_pkg::TS_SECOND) begin
          commit      = 1'b1;
          time_step_d = cas_pkg::TS_NORMAL;
        end else begin
          time_step_d = time_step_q + 3'd1;
        end
      end
      cas_pkg::OP_ALARM_SET: begin
        if (alarm_step_q >= cas_pkg::AS_MINUTE) begin
          alarm_step_d = cas_pkg::AS_NORMAL;
        end else begin
          alarm_step_d = alarm_step_q + 2'd1;
        end
      end
      cas_pkg::OP_INC, cas_pkg::OP_DEC: begin
        if (time_step_q != cas_pkg::TS_NORMAL) begin
          case (time_step_q)
            cas_pkg::TS_YEAR:   year_d   = adj_res;
            cas_pkg::TS_MONTH:  month_d  = adj_res[3:0];
            cas_pkg::TS_DAY:    day_d    = adj_res[4:0];
            cas_pkg::TS_HOUR:   hour_d   = adj_res[4:0];
            cas_pkg::TS_MINUTE: minute_d = adj_res[5:0];
            cas_pkg::TS_SECOND: second_d = adj_res[5:0];
            default: ;
          endcase
        end else if (alarm_step_q == cas_pkg::AS_HOUR) begin
          wake_hour_d = adj_res[4:0];
        end else if (alarm_step_q == cas_pkg::AS_MINUTE) begin
          wake_minute_d = adj_res[5:0];
        end
      end
      cas_pkg::OP_TICK: begin
        ring = item_i.alarm_switch && (item_i.now_hour == wake_hour_q) &&
               (item_i.now_minute == wake_minute_q) && (item_i.now_second == 6'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q   <= cas_pkg::TS_NORMAL;
      alarm_step_q  <= cas_pkg::AS_NORMAL;
      year_q        <= '0;
      month_q       <= '0;
      day_q         <= '0;
      hour_q        <= '0;
      minute_q      <= '0;
      second_q      <= '0;
      wake_hour_q   <= cas_pkg::WAKE_HOUR_RST;
      wake_minute_q <= cas_pkg::WAKE_MINUTE_RST;
    end else if (en_i) begin
      time_step_q   <= time_step_d;
      alarm_step_q  <= alarm_step_d;
      year_q        <= year_d;
      month_q       <= month_d;
      day_q         <= day_d;
      hour_q        <= hour_d;
      minute_q      <= minute_d;
      second_q      <= second_d;
      wake_hour_q   <= wake_hour_d;
      wake_minute_q <= wake_minute_d;
    end
  end

  // The result shows the state after the transaction.
  always_comb begin
    result_o.time_step   = time_step_d;
    result_o.alarm_step  = alarm_step_d;
    result_o.edit_year   = year_d;
    result_o.edit_month  = month_d;
    result_o.edit_day    = day_d;
    result_o.edit_hour   = hour_d;
    result_o.edit_minute = minute_d;
    result_o.edit_second = second_d;
    result_o.wake_hour   = wake_hour_d;
    result_o.wake_minute = wake_minute_d;
    result_o.commit_time = commit;
    result_o.ring        = ring;
  end

  // A commit always returns the date/time sequence to normal display.
  a_commit_ends_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && commit |=> time_step_q == cas_pkg::TS_NORMAL)
    else $error("commit did not end the edit sequence");

  // A commit can only leave the second step.
  a_commit_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> time_step_q >= cas_pkg::TS_SECOND)
    else $error("commit raised before the last edit step");

  // The alarm time moves only while the clock is not being edited.
  a_wake_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && time_step_q != cas_pkg::TS_NORMAL |=> $stable(wake_hour_q) && $stable(wake_minute_q))
    else $error("alarm time changed during clock editing");

endmodule

// File: hw/rtl/clock_set_and_alarm_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock set and alarm controller core
// Steps the date/time and alarm edit sequences on button and tick events
// and raises the commit and ring pulses.
// ----------------------------------------------------------------------------
// Structure: an accepted transaction passes the input register, then the
// result register, which holds it until the consumer takes it.
// Throughput: one transaction per cycle unless the result side stalls;
// one edit-logic pass from the input register updates the controller state.
// Reset: asynchronous and active low; both registers empty, edit steps at
// normal display, edit buffer zero, alarm time 06:30.
// ----------------------------------------------------------------------------
module clock_set_and_alarm_controller_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Event channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cas_pkg::in_item_t  in_data_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cas_pkg::out_item_t out_data_o
);

  logic               in_valid_q;
  cas_pkg::in_item_t  in_data_q;
  logic               out_valid_q;
  cas_pkg::out_item_t out_data_q;
  cas_pkg::out_item_t result;
  logic               advance;
  logic               in_take;

  // The held event moves into the result register whenever that register
  // is empty or its transaction completes in this cycle. The controller
  // state is committed at the same edge, so the next event sees it.
  assign advance = in_valid_q && (!out_valid_q || !out_stall_i);

  // The input register takes a new event unless it holds one that cannot
  // move on; this lets an event wait here while a result is still pending.
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
  end

  cas_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_data_q),
    .result_o (result)
  );

  // Result register: holds its transaction until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A committed edit buffer always comes with the step back at normal.
  a_commit_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.commit_time |-> out_data_o.time_step == cas_pkg::TS_NORMAL)
    else $error("commit reported outside normal display");

  // A tick never commits and a button never rings.
  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.commit_time && out_data_o.ring))
    else $error("commit and ring raised together");

  // The input side stalls only when a full result register is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  // Every event that moves on produces a result at the next edge.
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("event advanced without a result");

endmodule
